### rtl/ppbd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the packed pixel 2x2 box downsampler.
package ppbd_pkg;

    localparam int PIXEL_W           = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 12;
    localparam int DEFAULT_MAX_WIDTH = 2048;

    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_ARGB8    = 2'd0;
    localparam fmt_t FMT_A1R5G5B5 = 2'd1;
    localparam fmt_t FMT_A4R4G4B4 = 2'd2;
    localparam fmt_t FMT_R5G6B5   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 12'd2048;

    // Line store access control for one cycle.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ls_ctrl_t;

endpackage

### rtl/ppbd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: source pixels, result pixels and register writes.
interface ppbd_in_if;
    import ppbd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] source_pixel;
    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

interface ppbd_out_if;
    import ppbd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] dest_pixel;
    logic               frame_last;
    modport source (output valid, output dest_pixel, output frame_last, input ready);
    modport sink   (input valid, input dest_pixel, input frame_last, output ready);
endinterface

interface ppbd_cfg_if;
    import ppbd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ppbd_line_store.sv
`timescale 1ns / 1ps
// Single-port line store holding the even source row, registered read data.
module ppbd_line_store #(
    parameter int DEPTH = ppbd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                             clk,
    input  ppbd_pkg::ls_ctrl_t               ctrl,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    input  logic [ppbd_pkg::PIXEL_W-1:0]     wr_data,
    output logic [ppbd_pkg::PIXEL_W-1:0]     rd_data
);
    import ppbd_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ppbd_avg.sv
`timescale 1ns / 1ps
// Per-format 2x2 channel averaging with rounding, and alpha vote for A1R5G5B5.
module ppbd_avg (
    input  ppbd_pkg::fmt_t               fmt,
    input  logic [ppbd_pkg::PIXEL_W-1:0] up_l,
    input  logic [ppbd_pkg::PIXEL_W-1:0] up_r,
    input  logic [ppbd_pkg::PIXEL_W-1:0] dn_l,
    input  logic [ppbd_pkg::PIXEL_W-1:0] dn_r,
    output logic [ppbd_pkg::PIXEL_W-1:0] result
);
    import ppbd_pkg::*;

    // (a+b+c+d+2)>>2 on zero-extended fields; narrow fields stay narrow.
    function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
        logic [9:0] s;
        s = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
        return s[9:2];
    endfunction

    logic [7:0] b3, b2, b1, b0;
    logic [7:0] a5r, a5g, a5b;
    logic [7:0] a4a, a4r, a4g, a4b;
    logic [7:0] r5r, r6g, r5b;
    logic [2:0] votes;

    always_comb
    begin
        b3  = avg4(up_l[31:24], up_r[31:24], dn_l[31:24], dn_r[31:24]);
        b2  = avg4(up_l[23:16], up_r[23:16], dn_l[23:16], dn_r[23:16]);
        b1  = avg4(up_l[15:8],  up_r[15:8],  dn_l[15:8],  dn_r[15:8]);
        b0  = avg4(up_l[7:0],   up_r[7:0],   dn_l[7:0],   dn_r[7:0]);

        a5r = avg4(8'(up_l[14:10]), 8'(up_r[14:10]), 8'(dn_l[14:10]), 8'(dn_r[14:10]));
        a5g = avg4(8'(up_l[9:5]),   8'(up_r[9:5]),   8'(dn_l[9:5]),   8'(dn_r[9:5]));
        a5b = avg4(8'(up_l[4:0]),   8'(up_r[4:0]),   8'(dn_l[4:0]),   8'(dn_r[4:0]));
        votes = 3'(up_l[15]) + 3'(up_r[15]) + 3'(dn_l[15]) + 3'(dn_r[15]);

        a4a = avg4(8'(up_l[15:12]), 8'(up_r[15:12]), 8'(dn_l[15:12]), 8'(dn_r[15:12]));
        a4r = avg4(8'(up_l[11:8]),  8'(up_r[11:8]),  8'(dn_l[11:8]),  8'(dn_r[11:8]));
        a4g = avg4(8'(up_l[7:4]),   8'(up_r[7:4]),   8'(dn_l[7:4]),   8'(dn_r[7:4]));
        a4b = avg4(8'(up_l[3:0]),   8'(up_r[3:0]),   8'(dn_l[3:0]),   8'(dn_r[3:0]));

        r5r = avg4(8'(up_l[15:11]), 8'(up_r[15:11]), 8'(dn_l[15:11]), 8'(dn_r[15:11]));
        r6g = avg4(8'(up_l[10:5]),  8'(up_r[10:5]),  8'(dn_l[10:5]),  8'(dn_r[10:5]));
        r5b = avg4(8'(up_l[4:0]),   8'(up_r[4:0]),   8'(dn_l[4:0]),   8'(dn_r[4:0]));

        case (fmt)
            FMT_ARGB8:    result = {b3, b2, b1, b0};
            FMT_A1R5G5B5: result = {16'd0, (votes >= 3'd2), a5r[4:0], a5g[4:0], a5b[4:0]};
            FMT_A4R4G4B4: result = {16'd0, a4a[3:0], a4r[3:0], a4g[3:0], a4b[3:0]};
            FMT_R5G6B5:   result = {16'd0, r5r[4:0], r6g[5:0], r5b[4:0]};
            default:      result = '0;
        endcase
    end

endmodule

### rtl/packed_pixel_box_downsample_2x2.sv
`timescale 1ns / 1ps
// Packed pixel 2x2 box downsampler: line store, position counters and output register.
//
// Usage
//   src : source pixel words in raster order, one per cycle while ready is high.
//   dst : one averaged word per 2x2 block, frame_last set on the final one.
//   cfg : register writes (0 pixel format, 1 source width, 2 source height),
//         always ready; a write to a valid index restarts the image at the top
//         left. Write registers only while the block is idle.
// Pipeline: the bottom-right pixel of a block and its line store data are
//   captured at the edge that accepts the pixel; the result word is loaded
//   into the output register when the read stage fires, which a stalled
//   dst can hold back.
// Throughput: one source word per cycle while src.ready is high. The single
//   line store port is shared: even rows write, odd rows read, never both at once.
// Reset: counters restart at the top left, format ARGB8, width and height
//   2048. The line store is not cleared; every entry read on an odd row is
//   written on the even row before it.
// Stall: with dst stalled and a result word already waiting, a second
//   result may sit in the read stage; src.ready drops only then.
//
module packed_pixel_box_downsample_2x2 #(
    parameter int MAX_WIDTH = ppbd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    ppbd_in_if.sink          src,
    ppbd_out_if.source       dst,
    ppbd_cfg_if.sink         cfg
);
    import ppbd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W;

    // Configuration registers
    fmt_t                  fmt_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Position of the next source word
    logic [ADDR_W-1:0]     col_reg, col_next;
    logic [CFG_DATA_W-1:0] row_reg, row_next;

    // Read stage: odd-row word waiting for its line store data
    logic               s1_valid_reg;
    logic               s1_emit_reg;      // right pixel of a pair, completes a block
    logic               s1_last_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;

    logic [PIXEL_W-1:0] held_left_reg;    // bottom-left pixel of current block
    logic [PIXEL_W-1:0] up_l_reg;         // top-left pixel of current block

    // Output register
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_last_reg;

    logic               in_acc;
    logic               cfg_acc;
    logic               cfg_hit;
    logic               s1_stall;
    logic               s1_fire;
    ls_ctrl_t           ls_ctrl;
    logic [PIXEL_W-1:0] rd_data;
    logic [PIXEL_W-1:0] avg_pixel;

    logic [WW-1:0]         w_raw;
    logic [WW-1:0]         eff_w;
    logic [CFG_DATA_W-1:0] eff_h;
    logic [WW-1:0]         col_inc;
    logic [CFG_DATA_W:0]   row_inc;
    logic [WW-1:0]         last_col;
    logic [CFG_DATA_W-1:0] last_row;
    logic                  at_last;

    // Effective geometry: width clamped to [2, MAX_WIDTH], height at least 2.
    always_comb
    begin
        w_raw = WW'(width_reg);
        if (w_raw < WW'(2))
            eff_w = WW'(2);
        else if (w_raw > WW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = w_raw;
        eff_h    = (height_reg < CFG_DATA_W'(2)) ? CFG_DATA_W'(2) : height_reg;
        last_col = {eff_w[WW-1:1], 1'b0} - WW'(1);
        last_row = {eff_h[CFG_DATA_W-1:1], 1'b0} - CFG_DATA_W'(1);
        at_last  = (WW'(col_reg) == last_col) && (row_reg == last_row);
    end

    // Handshakes. A completing word in the read stage needs the output register.
    assign s1_stall  = s1_valid_reg && s1_emit_reg && out_valid_reg && !dst.ready;
    assign s1_fire   = s1_valid_reg && !s1_stall;
    assign src.ready = !s1_stall;
    assign in_acc    = src.valid && src.ready;
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_acc && (cfg.index == REG_FORMAT || cfg.index == REG_WIDTH ||
                                   cfg.index == REG_HEIGHT);

    // Raster counters
    always_comb
    begin
        col_inc  = WW'(col_reg) + WW'(1);
        row_inc  = {1'b0, row_reg} + (CFG_DATA_W + 1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_inc >= eff_w)
            begin
                col_next = '0;
                if (row_inc >= {1'b0, eff_h})
                    row_next = '0;
                else
                    row_next = row_inc[CFG_DATA_W-1:0];
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end
    end

    // Even rows write the store, odd rows read the entry above.
    assign ls_ctrl.wr_en = in_acc && !row_reg[0];
    assign ls_ctrl.rd_en = in_acc && row_reg[0];

    ppbd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .ctrl    (ls_ctrl),
        .addr    (col_reg),
        .wr_data (src.source_pixel),
        .rd_data (rd_data)
    );

    ppbd_avg u_avg (
        .fmt    (fmt_reg),
        .up_l   (up_l_reg),
        .up_r   (rd_data),
        .dn_l   (held_left_reg),
        .dn_r   (s1_pixel_reg),
        .result (avg_pixel)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_ARGB8;
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_left_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;

            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_FORMAT: fmt_reg    <= cfg.data[1:0];
                    REG_WIDTH:  width_reg  <= cfg.data;
                    REG_HEIGHT: height_reg <= cfg.data;
                    default:    ;
                endcase
            end

            if (!s1_stall)
                s1_valid_reg <= in_acc && row_reg[0];

            if (cfg_hit)
                held_left_reg <= '0;
            else if (s1_fire && !s1_emit_reg)
                held_left_reg <= s1_pixel_reg;

            if (s1_fire && s1_emit_reg)
                out_valid_reg <= 1'b1;
            else if (dst.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_acc && !s1_stall)
        begin
            s1_pixel_reg <= src.source_pixel;
            s1_emit_reg  <= col_reg[0];
            s1_last_reg  <= at_last;
        end
        if (s1_fire && !s1_emit_reg)
            up_l_reg <= rd_data;
        if (s1_fire && s1_emit_reg)
        begin
            out_pixel_reg <= avg_pixel;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign dst.valid      = out_valid_reg;
    assign dst.dest_pixel = out_pixel_reg;
    assign dst.frame_last = out_last_reg;

`ifndef ASSERT_OFF
    // Input back-pressure only comes from a blocked output word.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !src.ready |-> (dst.valid && !dst.ready))
        else $error("src.ready low without output stall");

    // A completing word leaving the read stage lands in the output register.
    a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_emit_reg) |=> dst.valid)
        else $error("block result lost between read stage and output");

    // A register write restarts the raster position.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not restarted after register write");

    // Line store is never written and read in the same cycle.
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ls_ctrl.wr_en |-> !ls_ctrl.rd_en)
        else $error("line store write and read in same cycle");
`endif

endmodule
